### rtl/disk_request_scheduler_core_macros.svh
// Assertion helpers used by the scheduler front end.
// Each macro expects signals named clk and rst in the calling module.
`ifndef DISK_REQUEST_SCHEDULER_CORE_MACROS_SVH
`define DISK_REQUEST_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DRSC_ASSERT_IMPL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DRSC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### rtl/drsc_pkg.sv
package drsc_pkg;

  localparam int QUEUE_DEPTH_DEF   = 32;
  localparam int CYLINDER_BITS_DEF = 10;

  // Fixed field widths of the streams and registers
  localparam int CYL_FIELD_W  = 10;
  localparam int DIST_W       = 10;
  localparam int TOTAL_W      = 16;
  localparam int MODE_W       = 2;
  localparam int CCOUNT_W     = 11;
  localparam int ADDR_W       = 5;
  localparam int REG_IDX_W    = 3;

  // Stop queue between front and back
  localparam int STOP_FIFO_DEPTH = 4;
  localparam int QPTR_W          = $clog2(STOP_FIFO_DEPTH);
  localparam int QLVL_W          = $clog2(STOP_FIFO_DEPTH + 1);

  // Policy codes
  localparam logic [MODE_W-1:0] MODE_FCFS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_HEAD   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOP    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_THRESH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CCOUNT = 3'd4;

  // Register reset values
  localparam logic [CYL_FIELD_W-1:0] HEAD_RESET   = 10'd0;
  localparam logic [MODE_W-1:0]      MODE_RESET   = MODE_FCFS;
  localparam logic [CYL_FIELD_W-1:0] TOP_RESET    = 10'd199;
  localparam logic [CYL_FIELD_W-1:0] THRESH_RESET = 10'd100;
  localparam logic [CCOUNT_W-1:0]    CCOUNT_RESET = 11'd200;

  typedef struct packed {
    logic [CYL_FIELD_W-1:0] head_position;
    logic [MODE_W-1:0]      policy_mode;
    logic [CYL_FIELD_W-1:0] top_cylinder;
    logic [CYL_FIELD_W-1:0] direction_threshold;
    logic [CCOUNT_W-1:0]    cylinder_count;
  } cfg_t;

  typedef struct packed {
    logic                   last;
    logic                   endpoint;
    logic [CYL_FIELD_W-1:0] cyl;
  } stop_t;

endpackage

### rtl/drsc_front.sv
`include "disk_request_scheduler_core_macros.svh"

module drsc_front #(
  parameter int QUEUE_DEPTH   = drsc_pkg::QUEUE_DEPTH_DEF,
  parameter int CYLINDER_BITS = drsc_pkg::CYLINDER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  drsc_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [drsc_pkg::CYL_FIELD_W-1:0] cylinder,
  input  logic                             last,
  input  logic [drsc_pkg::QLVL_W-1:0]      q_level,
  output logic                             push_valid,
  output drsc_pkg::stop_t                  push_item
);

  localparam int CYL_W = (CYLINDER_BITS < drsc_pkg::CYL_FIELD_W) ?
                         CYLINDER_BITS : drsc_pkg::CYL_FIELD_W;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QL_W  = drsc_pkg::QLVL_W;
  localparam int QS_W  = QL_W + 1;
  localparam int FW    = drsc_pkg::CYL_FIELD_W;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_CLASS = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_SEG1  = 3'd3;
  localparam logic [2:0] ST_ENDPT = 3'd4;
  localparam logic [2:0] ST_SEG2  = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] remain;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] ge;
  logic [IDX_W-1:0] idx;
  logic             down;
  logic             use_arr;

  logic [CYL_W-1:0] sorted  [QUEUE_DEPTH];
  logic [CYL_W-1:0] arrival [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gt;

  logic             rd_valid;
  logic             rd_is_ep;
  logic             rd_from_arr;
  logic             rd_last;
  logic [FW-1:0]    rd_ep_val;
  logic [CYL_W-1:0] srt_q;
  logic [CYL_W-1:0] arr_q;

  logic             in_acc;
  logic             store_we;
  logic [CYL_W-1:0] cyl_m;
  logic [CYL_W-1:0] head_m;
  logic             has_ep;
  logic             cscan_up;
  logic             can_issue;
  logic             issue;
  logic             issue_last;
  logic [IDX_W-1:0] rd_addr;
  logic [CYL_W-1:0] rd_word;
  logic [IDX_W-1:0] idx_step;
  logic [CNT_W-1:0] lo_m1;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] seg2_idx;
  logic [CNT_W-1:0] seg2_cnt;
  logic             seg2_down;
  logic [FW-1:0]    ep_val;

  assign in_ready = (state == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign cyl_m    = cylinder[CYL_W-1:0];
  assign head_m   = cfg.head_position[CYL_W-1:0];
  assign store_we = in_acc && (count < CNT_W'(QUEUE_DEPTH));

  assign has_ep   = (cfg.policy_mode == drsc_pkg::MODE_SCAN) ||
                    (cfg.policy_mode == drsc_pkg::MODE_CSCAN);
  assign cscan_up = (FW'(head_m) >= cfg.direction_threshold);
  assign ep_val   = ((cfg.policy_mode == drsc_pkg::MODE_CSCAN) && !cscan_up) ?
                    FW'(cfg.top_cylinder[CYL_W-1:0]) : '0;

  assign lo_m1  = lo - CNT_W'(1);
  assign cnt_m1 = count - CNT_W'(1);

  always_comb begin
    if (cfg.policy_mode == drsc_pkg::MODE_SCAN) begin
      seg2_idx  = lo[IDX_W-1:0];
      seg2_cnt  = count - lo;
      seg2_down = 1'b0;
    end else if (cscan_up) begin
      seg2_idx  = '0;
      seg2_cnt  = ge;
      seg2_down = 1'b0;
    end else begin
      seg2_idx  = cnt_m1[IDX_W-1:0];
      seg2_cnt  = count - lo;
      seg2_down = 1'b1;
    end
  end

  // Insertion chain: every entry above the insertion point shifts up by one
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < count) && (sorted[i] > cyl_m);
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_chain
    logic             shift_in;
    logic [CYL_W-1:0] prev_val;
    logic             wr_en;
    if (g == 0) begin : g_first
      assign shift_in = 1'b0;
      assign prev_val = '0;
    end else begin : g_rest
      assign shift_in = gt[g-1];
      assign prev_val = sorted[g-1];
    end
    assign wr_en = store_we && (gt[g] || (CNT_W'(g) == count));
    always_ff @(posedge clk) begin
      if (wr_en) begin
        sorted[g] <= shift_in ? prev_val : cyl_m;
      end
    end
  end

  assign rd_addr  = (state == ST_CLASS) ? remain[IDX_W-1:0] : idx;
  assign rd_word  = sorted[rd_addr];
  assign idx_step = down ? (idx - IDX_W'(1)) : (idx + IDX_W'(1));

  assign can_issue = (QS_W'(q_level) + QS_W'(rd_valid)) < QS_W'(drsc_pkg::STOP_FIFO_DEPTH);
  assign issue = can_issue && (((state == ST_SEG1) && (remain != '0)) ||
                               (state == ST_ENDPT) || (state == ST_SEG2));
  assign issue_last = ((state == ST_SEG1) && (remain == CNT_W'(1)) && !has_ep) ||
                      ((state == ST_ENDPT) && (seg2_cnt == '0)) ||
                      ((state == ST_SEG2) && (remain == CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (store_we) begin
              count <= count + CNT_W'(1);
            end
            if (last) begin
              lo     <= '0;
              ge     <= '0;
              remain <= '0;
              state  <= ST_CLASS;
            end
          end
        end
        ST_CLASS: begin
          if (remain == count) begin
            state <= ST_START;
          end else begin
            if (rd_word <= head_m) begin
              lo <= lo + CNT_W'(1);
            end
            if (rd_word < head_m) begin
              ge <= ge + CNT_W'(1);
            end
            remain <= remain + CNT_W'(1);
          end
        end
        ST_START: begin
          state <= ST_SEG1;
          if ((cfg.policy_mode == drsc_pkg::MODE_SCAN) ||
              ((cfg.policy_mode == drsc_pkg::MODE_CSCAN) && !cscan_up)) begin
            idx     <= lo_m1[IDX_W-1:0];
            remain  <= lo;
            down    <= 1'b1;
            use_arr <= 1'b0;
          end else if (cfg.policy_mode == drsc_pkg::MODE_CSCAN) begin
            idx     <= ge[IDX_W-1:0];
            remain  <= count - ge;
            down    <= 1'b0;
            use_arr <= 1'b0;
          end else begin
            idx     <= '0;
            remain  <= count;
            down    <= 1'b0;
            use_arr <= 1'b1;
          end
        end
        ST_SEG1: begin
          if (remain == '0) begin
            if (has_ep) begin
              state <= ST_ENDPT;
            end else begin
              state <= ST_LOAD;
              count <= '0;
            end
          end else if (can_issue) begin
            idx    <= idx_step;
            remain <= remain - CNT_W'(1);
            if (remain == CNT_W'(1)) begin
              if (has_ep) begin
                state <= ST_ENDPT;
              end else begin
                state <= ST_LOAD;
                count <= '0;
              end
            end
          end
        end
        ST_ENDPT: begin
          if (can_issue) begin
            idx     <= seg2_idx;
            remain  <= seg2_cnt;
            down    <= seg2_down;
            use_arr <= 1'b0;
            if (seg2_cnt == '0) begin
              state <= ST_LOAD;
              count <= '0;
            end else begin
              state <= ST_SEG2;
            end
          end
        end
        ST_SEG2: begin
          if (can_issue) begin
            idx    <= idx_step;
            remain <= remain - CNT_W'(1);
            if (remain == CNT_W'(1)) begin
              state <= ST_LOAD;
              count <= '0;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Arrival-order memory: written at the fill count, read while serving FCFS
  always_ff @(posedge clk) begin
    if (store_we) begin
      arrival[count[IDX_W-1:0]] <= cyl_m;
    end
    if (issue) begin
      arr_q <= arrival[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      srt_q       <= rd_word;
      rd_is_ep    <= (state == ST_ENDPT);
      rd_from_arr <= use_arr;
      rd_last     <= issue_last;
      rd_ep_val   <= ep_val;
    end
  end

  assign push_valid         = rd_valid;
  assign push_item.last     = rd_last;
  assign push_item.endpoint = rd_is_ep;
  assign push_item.cyl      = rd_is_ep ? rd_ep_val : FW'(rd_from_arr ? arr_q : srt_q);

  `DRSC_ASSERT_IMPL(a_push_has_room, push_valid, q_level < QL_W'(drsc_pkg::STOP_FIFO_DEPTH), "stop pushed into a full queue")
  `DRSC_ASSERT_NEXT(a_final_stop_reloads, issue && issue_last, state == ST_LOAD, "final stop did not return to loading")
  `DRSC_ASSERT_IMPL(a_seg2_nonempty, state == ST_SEG2, remain != '0, "second sweep entered with nothing to serve")

endmodule

### rtl/drsc_queue.sv
module drsc_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  drsc_pkg::stop_t             push_item,
  input  logic                        pop,
  output logic                        not_empty,
  output drsc_pkg::stop_t             head_item,
  output logic [drsc_pkg::QLVL_W-1:0] level
);

  localparam int PW = drsc_pkg::QPTR_W;
  localparam int LW = drsc_pkg::QLVL_W;

  drsc_pkg::stop_t mem [drsc_pkg::STOP_FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;

  assign not_empty = (level != '0);
  assign head_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + LW'(1);
      end else if (pop && !push) begin
        level <= level - LW'(1);
      end
    end
  end

endmodule

### rtl/drsc_back.sv
module drsc_back #(
  parameter int CYLINDER_BITS = drsc_pkg::CYLINDER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  drsc_pkg::cfg_t                   cfg,
  input  logic                             q_valid,
  input  drsc_pkg::stop_t                  q_item,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [drsc_pkg::CYL_FIELD_W-1:0] out_cyl,
  output logic [drsc_pkg::DIST_W-1:0]      out_dist,
  output logic                             out_ep,
  output logic [drsc_pkg::TOTAL_W-1:0]     out_total,
  output logic                             out_last
);

  localparam int CYL_W = (CYLINDER_BITS < drsc_pkg::CYL_FIELD_W) ?
                         CYLINDER_BITS : drsc_pkg::CYL_FIELD_W;
  localparam int FW = drsc_pkg::CYL_FIELD_W;
  localparam int TW = drsc_pkg::TOTAL_W;

  logic          first;
  logic [FW-1:0] prev;
  logic [TW-1:0] sum;

  logic [FW-1:0] base;
  logic [FW-1:0] seek;
  logic [TW-1:0] sum_base;
  logic [TW:0]   sum_wide;
  logic [TW-1:0] sum_new;
  logic [TW-1:0] total;

  assign base     = first ? FW'(cfg.head_position[CYL_W-1:0]) : prev;
  assign seek     = (q_item.cyl >= base) ? (q_item.cyl - base) : (base - q_item.cyl);
  assign sum_base = first ? '0 : sum;
  assign sum_wide = (TW+1)'(sum_base) + (TW+1)'(seek);
  assign sum_new  = sum_wide[TW] ? '1 : sum_wide[TW-1:0];
  assign total    = (cfg.policy_mode == drsc_pkg::MODE_CSCAN) ?
                    TW'(cfg.cylinder_count) : sum_new;

  assign pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      first     <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b1;
      first     <= q_item.last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prev      <= q_item.cyl;
      sum       <= sum_new;
      out_cyl   <= q_item.cyl;
      out_dist  <= seek;
      out_ep    <= q_item.endpoint;
      out_total <= q_item.last ? total : '0;
      out_last  <= q_item.last;
    end
  end

endmodule

### rtl/disk_request_scheduler_core.sv
// Disk request scheduler: FCFS, SCAN and C-SCAN service order for a batch.
// Input stream (s_*): one cylinder request per transaction, tlast closes the
// batch. Requests load one per cycle into a sorted insertion chain and an
// arrival-order memory; requests beyond the store depth are dropped, a
// dropped one with tlast still closes the batch.
// Output stream (m_*): one transaction per stop with cylinder, seek distance
// and endpoint flag; tlast and the total seek ride on the final stop.
// After the closing request, a classification scan walks the n stored
// requests, one sorted entry per cycle plus the end check, and a setup
// state follows; each stop then passes the read register, the stop queue
// and the output register. Stops stream at one per cycle while the stop
// queue has room, set by the single read port of the stores.
// s_tready is low from the closing request until the last stop of the batch
// has been read from the stores; the next batch may load while the back end
// still drains earlier stops from the four-entry stop queue.
// A stalled receiver holds the output register; the queue fills and the
// front end pauses issuing until room opens, so nothing is lost.
// Reset (rst, synchronous) clears the fill count and queue and loads register defaults;
// no clearing pass is needed. Registers sit on an APB-style port at byte addresses
// 0, 4, 8, 12 and 16; the user must change them only when idle, not enforced by the block.
module disk_request_scheduler_core #(
  parameter int QUEUE_DEPTH   = drsc_pkg::QUEUE_DEPTH_DEF,
  parameter int CYLINDER_BITS = drsc_pkg::CYLINDER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Request stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,  // [9:0] cylinder
  input  logic                        s_tlast,
  // Stop stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata,  // [9:0] cylinder_res, [19:10] seek_distance,
                                                // [35:20] total_seek
  output logic [0:0]                  m_tuser,  // [0] is_endpoint
  output logic                        m_tlast
);

  drsc_pkg::cfg_t  cfg;
  logic            cfg_wr;
  logic [drsc_pkg::REG_IDX_W-1:0] reg_idx;

  logic                        push_valid;
  drsc_pkg::stop_t             push_item;
  logic                        pop;
  logic                        q_valid;
  drsc_pkg::stop_t             q_item;
  logic [drsc_pkg::QLVL_W-1:0] q_level;

  logic [drsc_pkg::CYL_FIELD_W-1:0] out_cyl;
  logic [drsc_pkg::DIST_W-1:0]      out_dist;
  logic [drsc_pkg::TOTAL_W-1:0]     out_total;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[drsc_pkg::ADDR_W-1:2];

  // Register file: write on the access phase, ignore addresses past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_position       <= drsc_pkg::HEAD_RESET;
      cfg.policy_mode         <= drsc_pkg::MODE_RESET;
      cfg.top_cylinder        <= drsc_pkg::TOP_RESET;
      cfg.direction_threshold <= drsc_pkg::THRESH_RESET;
      cfg.cylinder_count      <= drsc_pkg::CCOUNT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        drsc_pkg::REG_HEAD:   cfg.head_position       <= pwdata[drsc_pkg::CYL_FIELD_W-1:0];
        drsc_pkg::REG_MODE:   cfg.policy_mode         <= pwdata[drsc_pkg::MODE_W-1:0];
        drsc_pkg::REG_TOP:    cfg.top_cylinder        <= pwdata[drsc_pkg::CYL_FIELD_W-1:0];
        drsc_pkg::REG_THRESH: cfg.direction_threshold <= pwdata[drsc_pkg::CYL_FIELD_W-1:0];
        drsc_pkg::REG_CCOUNT: cfg.cylinder_count      <= pwdata[drsc_pkg::CCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register, zero past the list
  always_comb begin
    unique case (reg_idx)
      drsc_pkg::REG_HEAD:   prdata = 32'(cfg.head_position);
      drsc_pkg::REG_MODE:   prdata = 32'(cfg.policy_mode);
      drsc_pkg::REG_TOP:    prdata = 32'(cfg.top_cylinder);
      drsc_pkg::REG_THRESH: prdata = 32'(cfg.direction_threshold);
      drsc_pkg::REG_CCOUNT: prdata = 32'(cfg.cylinder_count);
      default:              prdata = '0;
    endcase
  end

  // Front: load, sort, classify against the head, walk the service order
  drsc_front #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .cylinder   (s_tdata[drsc_pkg::CYL_FIELD_W-1:0]),
    .last       (s_tlast),
    .q_level    (q_level),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // Short stop queue decouples the walk from the output handshake
  drsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (q_valid),
    .head_item (q_item),
    .level     (q_level)
  );

  // Back: seek distance, running total, output register
  drsc_back #(
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_cyl   (out_cyl),
    .out_dist  (out_dist),
    .out_ep    (m_tuser[0]),
    .out_total (out_total),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0, out_total, out_dist, out_cyl};

endmodule

### test/tb_disk_request_scheduler_core.sv
`timescale 1ns / 1ps

module tb_disk_request_scheduler_core;
  import drsc_pkg::*;

  // Mode 3 has no name in the package; the block treats it as first come first served.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int IDLE_PCT       = 18;
  localparam int RANDOM_ITEMS   = 320;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 4000;

  // One stop of the service order as it leaves on the m_* stream.
  typedef struct packed {
    logic [CYL_FIELD_W-1:0] cyl;
    logic [DIST_W-1:0]      seek;
    logic                   endpoint;
    logic [TOTAL_W-1:0]     total;
    logic                   last;
  } stop_rec_t;

  typedef enum logic [0:0] {ROW_CFG, ROW_REQ} row_kind_e;

  // A row of the directed table: either a register write or one request.
  // Where typed is set, final_stop is the closing stop of the batch, read off by hand.
  typedef struct packed {
    row_kind_e              kind;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic [10:0]            value;
    logic                   last;
    logic                   typed;
    stop_rec_t              final_stop;
  } dir_row_t;

  localparam int DIR_ROWS = 40;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Defaults after reset: first come first served from head 0.
    '{ROW_REQ, REG_HEAD, 11'd1023, 1'b1, 1'b1, '{10'd1023, 10'd1023, 1'b0, 16'd1023, 1'b1}},
    '{ROW_REQ, REG_HEAD, 11'd0,    1'b1, 1'b1, '{10'd0, 10'd0, 1'b0, 16'd0, 1'b1}},
    // SCAN from 500, a request on the head itself goes down first.
    '{ROW_CFG, REG_MODE, {9'd0, MODE_SCAN}, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_HEAD, 11'd500, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd500, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd10,  1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd900, 1'b1, 1'b1, '{10'd900, 10'd900, 1'b0, 16'd1400, 1'b1}},
    // SCAN with an empty lower group still visits cylinder 0.
    '{ROW_REQ, REG_HEAD, 11'd1023, 1'b1, 1'b1, '{10'd1023, 10'd1023, 1'b0, 16'd1523, 1'b1}},
    // C-SCAN, head above the threshold: sweep up, wrap through 0.
    '{ROW_CFG, REG_MODE, {9'd0, MODE_CSCAN}, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd500, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd20,  1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd700, 1'b1, 1'b1, '{10'd20, 10'd20, 1'b0, 16'd200, 1'b1}},
    // C-SCAN, head below the threshold: sweep down, wrap through the top.
    '{ROW_CFG, REG_HEAD, 11'd50,   1'b0, 1'b0, '0},
    '{ROW_CFG, REG_TOP,  11'd1023, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd50, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd60, 1'b1, 1'b1, '{10'd60, 10'd963, 1'b0, 16'd200, 1'b1}},
    // Spare mode code falls back to arrival order.
    '{ROW_CFG, REG_MODE,   {9'd0, MODE_SPARE}, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_HEAD,   11'd0,    1'b0, 1'b0, '0},
    '{ROW_CFG, REG_CCOUNT, 11'd1024, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd5, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd3, 1'b1, 1'b1, '{10'd3, 10'd2, 1'b0, 16'd7, 1'b1}},
    // C-SCAN with head equal to threshold: the wrap endpoint closes the run.
    '{ROW_CFG, REG_MODE,   {9'd0, MODE_CSCAN}, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_THRESH, 11'd0, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd0, 1'b1, 1'b1, '{10'd0, 10'd0, 1'b1, 16'd1024, 1'b1}},
    // SCAN from the top cylinder: the endpoint is the final stop.
    '{ROW_CFG, REG_MODE, {9'd0, MODE_SCAN}, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_HEAD, 11'd1023, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd1023, 1'b1, 1'b1, '{10'd0, 10'd1023, 1'b1, 16'd1023, 1'b1}},
    // Opposite extremes of the register ranges.
    '{ROW_CFG, REG_MODE,   {9'd0, MODE_CSCAN}, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_HEAD,   11'd0,    1'b0, 1'b0, '0},
    '{ROW_CFG, REG_THRESH, 11'd1023, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_TOP,    11'd1,    1'b0, 1'b0, '0},
    '{ROW_CFG, REG_CCOUNT, 11'd1,    1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd1023, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd0,    1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd512,  1'b1, 1'b0, '0},
    // Alternating bit patterns, duplicate requests and one on the head.
    '{ROW_CFG, REG_MODE, {9'd0, MODE_SCAN}, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_HEAD, 11'd341, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd682, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd341, 1'b0, 1'b0, '0},
    '{ROW_REQ, REG_HEAD, 11'd682, 1'b1, 1'b0, '0}
  };

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [15:0]            s_tdata;  // [9:0] cylinder
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [39:0]            m_tdata;  // [9:0] cylinder_res, [19:10] seek_distance,
                                    // [35:20] total_seek
  logic [0:0]             m_tuser;  // [0] is_endpoint
  logic                   m_tlast;

  // Shadow of the block: register copies, both request stores, run bookkeeping.
  logic [CYL_FIELD_W-1:0] cfg_head;
  logic [MODE_W-1:0]      cfg_mode;
  logic [CYL_FIELD_W-1:0] cfg_top;
  logic [CYL_FIELD_W-1:0] cfg_thresh;
  logic [CCOUNT_W-1:0]    cfg_ccount;
  logic [CYL_FIELD_W-1:0] req_in_order [QUEUE_DEPTH_DEF];
  logic [CYL_FIELD_W-1:0] req_by_cyl   [QUEUE_DEPTH_DEF];
  int                     stored_cnt;
  logic [CYL_FIELD_W-1:0] head_trail;
  int                     seek_sum;
  stop_rec_t              pending_stops [$];

  int                     err_cnt;
  int                     stall_cycles;
  logic                   no_idle;
  logic                   hold_req;

  disk_request_scheduler_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append one stop, measured from the previous one.
  function automatic void add_stop(input logic [CYL_FIELD_W-1:0] cyl, input logic endp);
    int        span;
    stop_rec_t stop;
    span = int'(cyl) - int'(head_trail);
    if (span < 0) span = -span;
    if (span > 1023) span = 1023;
    seek_sum += span;
    if (seek_sum > 65535) seek_sum = 65535;
    stop.cyl      = cyl;
    stop.seek     = span[DIST_W-1:0];
    stop.endpoint = endp;
    stop.total    = '0;
    stop.last     = 1'b0;
    pending_stops.push_back(stop);
    head_trail = cyl;
  endfunction

  // Store one accepted request; on the closing one, lay out the whole service order.
  function automatic void schedule_request(input logic [CYL_FIELD_W-1:0] cyl,
                                           input logic closes, input logic typed,
                                           input stop_rec_t typed_final);
    int        n;
    int        lo;
    int        ge;
    int        i;
    stop_rec_t fin;
    // Drop requests once the store is full; a dropped one may still close the batch.
    if (stored_cnt < QUEUE_DEPTH_DEF) begin
      req_in_order[stored_cnt] = cyl;
      i = stored_cnt;
      while (i > 0 && req_by_cyl[i-1] > cyl) begin
        req_by_cyl[i] = req_by_cyl[i-1];
        i--;
      end
      req_by_cyl[i] = cyl;
      stored_cnt++;
    end
    if (!closes) return;

    n          = stored_cnt;
    stored_cnt = 0;
    head_trail = cfg_head;
    seek_sum   = 0;
    // lo: requests at or below the head; ge: requests strictly below it.
    lo = 0;
    while (lo < n && req_by_cyl[lo] <= cfg_head) lo++;
    ge = 0;
    while (ge < n && req_by_cyl[ge] < cfg_head) ge++;

    case (cfg_mode)
      MODE_SCAN: begin
        for (i = lo; i > 0; i--) add_stop(req_by_cyl[i-1], 1'b0);
        add_stop('0, 1'b1);
        for (i = lo; i < n; i++) add_stop(req_by_cyl[i], 1'b0);
      end
      MODE_CSCAN: begin
        if (cfg_head >= cfg_thresh) begin
          for (i = ge; i < n; i++) add_stop(req_by_cyl[i], 1'b0);
          add_stop('0, 1'b1);
          for (i = 0; i < ge; i++) add_stop(req_by_cyl[i], 1'b0);
        end else begin
          for (i = lo; i > 0; i--) add_stop(req_by_cyl[i-1], 1'b0);
          add_stop(cfg_top, 1'b1);
          for (i = n; i > lo; i--) add_stop(req_by_cyl[i-1], 1'b0);
        end
      end
      default: begin
        for (i = 0; i < n; i++) add_stop(req_in_order[i], 1'b0);
      end
    endcase

    // Close the run: total and last ride on the final stop.
    fin = pending_stops.pop_back();
    if (typed) begin
      fin = typed_final;
    end else begin
      fin.total = (cfg_mode == MODE_CSCAN) ? {5'd0, cfg_ccount} : seek_sum[TOTAL_W-1:0];
      fin.last  = 1'b1;
    end
    pending_stops.push_back(fin);
  endfunction

  function automatic logic [CYL_FIELD_W-1:0] pick_cylinder();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return cfg_head;
      3: return cfg_head + CYL_FIELD_W'($urandom_range(2)) - 10'd1;
      default: return CYL_FIELD_W'($urandom_range(1023));
    endcase
  endfunction

  // Offer one request, hold it until the block takes it, then predict.
  task automatic send_request(input logic [CYL_FIELD_W-1:0] cyl, input logic closes,
                              input logic typed, input stop_rec_t typed_final);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, cyl};
    s_tlast  <= closes;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    schedule_request(cyl, closes, typed, typed_final);
  endtask

  // Write one register: setup cycle, access cycle, then release the bus.
  task automatic apb_store(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_HEAD:   cfg_head   = value[CYL_FIELD_W-1:0];
      REG_MODE:   cfg_mode   = value[MODE_W-1:0];
      REG_TOP:    cfg_top    = value[CYL_FIELD_W-1:0];
      REG_THRESH: cfg_thresh = value[CYL_FIELD_W-1:0];
      REG_CCOUNT: cfg_ccount = value[CCOUNT_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait until every expected stop is out, then let the block settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_stops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Phases 0, 1 pin the register extremes, others are random; mode = phase below 4.
  task automatic apply_random_config(input int phase);
    logic [CYL_FIELD_W-1:0] head;
    logic [MODE_W-1:0]      mode;
    logic [CYL_FIELD_W-1:0] top;
    logic [CYL_FIELD_W-1:0] thresh;
    logic [CCOUNT_W-1:0]    ccount;
    head   = CYL_FIELD_W'($urandom_range(1023));
    mode   = MODE_W'($urandom_range(3));
    top    = CYL_FIELD_W'($urandom_range(1, 1023));
    thresh = CYL_FIELD_W'($urandom_range(1023));
    ccount = CCOUNT_W'($urandom_range(1, 1024));
    if (phase < 4) mode = phase[MODE_W-1:0];
    if (phase == 0) begin
      head   = '0;
      top    = 10'd1;
      thresh = '1;
      ccount = 11'd1;
    end else if (phase == 1) begin
      head   = '1;
      top    = '1;
      thresh = '0;
      ccount = 11'd1024;
    end else if ($urandom_range(3) == 0) begin
      // Head right on the threshold: C-SCAN must sweep upward.
      thresh = head;
    end
    apb_store(REG_HEAD,   32'(head));
    apb_store(REG_MODE,   32'(mode));
    apb_store(REG_TOP,    32'(top));
    apb_store(REG_THRESH, 32'(thresh));
    apb_store(REG_CCOUNT, 32'(ccount));
  endtask

  // Compare one field of a stop, report and count a mismatch.
  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // Check each stop transaction against the oldest expectation.
  always @(posedge clk) begin : stop_check
    stop_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_stops.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected stop: expected none, actual cylinder %0d", $time,
                 m_tdata[9:0]);
      end else begin
        want = pending_stops.pop_front();
        check_field("cylinder_res",  want.cyl,      m_tdata[9:0]);
        check_field("seek_distance", want.seek,     m_tdata[19:10]);
        check_field("is_endpoint",   want.endpoint, m_tuser[0]);
        check_field("total_seek",    want.total,    m_tdata[35:20]);
        check_field("last_res",      want.last,     m_tlast);
      end
    end
  end

  // Count cycles with no transaction on any port; end the run if it hangs.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, a steady phase, and one long hold-off on request.
  initial begin : receiver
    int hold_cnt;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int nbatch;
    int batch_len;
    int rand_items;
    int i;
    int k;

    err_cnt      = 0;
    stall_cycles = 0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    stored_cnt   = 0;
    seek_sum     = 0;
    head_trail   = '0;
    cfg_head     = HEAD_RESET;
    cfg_mode     = MODE_RESET;
    cfg_top      = TOP_RESET;
    cfg_thresh   = THRESH_RESET;
    cfg_ccount   = CCOUNT_RESET;

    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table: registers change only once the block has drained.
    for (i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_drained();
        apb_store(DIRECTED[i].reg_idx, 32'(DIRECTED[i].value));
      end else begin
        send_request(DIRECTED[i].value[CYL_FIELD_W-1:0], DIRECTED[i].last,
                     DIRECTED[i].typed, DIRECTED[i].final_stop);
      end
    end

    // Random phases: new settings each phase, a few batches per phase.
    // Phase 2 runs with no idling on either side; phase 4 holds the receiver off
    // while batches of eight keep coming, so the stop queue fills and input stalls.
    phase      = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      wait_drained();
      apply_random_config(phase);
      no_idle = (phase == 2);
      if (phase == 4) hold_req = 1'b1;
      nbatch = $urandom_range(2, 5);
      repeat (nbatch) begin
        case ($urandom_range(19))
          0: batch_len = $urandom_range(33, 38);
          1: batch_len = $urandom_range(17, 32);
          default: batch_len = $urandom_range(1, 8);
        endcase
        if (phase == 4) batch_len = 8;
        for (k = 0; k < batch_len; k++) begin
          send_request(pick_cylinder(), k == batch_len - 1, 1'b0, '0);
        end
        rand_items += batch_len;
        // Now and then pause until the whole service order is out.
        if ($urandom_range(7) == 0) wait_drained();
      end
      phase++;
    end
    no_idle = 1'b0;

    wait_drained();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### disk_request_scheduler_core.f
+incdir+rtl
rtl/drsc_pkg.sv
rtl/drsc_front.sv
rtl/drsc_queue.sv
rtl/drsc_back.sv
rtl/disk_request_scheduler_core.sv
test/tb_disk_request_scheduler_core.sv
